// ===== design/aapi_pkg.sv =====
`default_nettype none
package aapi_pkg;

   localparam int DATA_W            = 32;
   localparam int CORDIC_STAGES_DEF = 28;
   localparam int ROOT_STEPS        = 32;
   localparam int DIV_BITS          = 31;
   localparam int CORDIC_W          = 36;
   localparam int CSR_ADDR_W        = 3;

   // register index carried by paddr[2]
   localparam logic CSR_IDX_MODE = 1'b0;

   localparam logic signed [CORDIC_W-1:0] PI_Q28      = 36'sd843314857;
   localparam logic signed [CORDIC_W-1:0] TWO_PI_Q28  = 36'sd1686629713;
   localparam logic signed [CORDIC_W-1:0] HALF_PI_Q28 = 36'sd421657428;
   localparam logic signed [CORDIC_W-1:0] GAIN_Q30    = 36'sd652032874;
   localparam logic signed [CORDIC_W-1:0] ONE_Q30     = 36'sd1073741824;

   typedef struct packed {
      logic signed [DATA_W-1:0] rot_x;
      logic signed [DATA_W-1:0] rot_y;
      logic signed [DATA_W-1:0] rot_z;
      logic signed [DATA_W-1:0] trans_x;
      logic signed [DATA_W-1:0] trans_y;
      logic signed [DATA_W-1:0] trans_z;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] m00;
      logic signed [DATA_W-1:0] m01;
      logic signed [DATA_W-1:0] m02;
      logic signed [DATA_W-1:0] m10;
      logic signed [DATA_W-1:0] m11;
      logic signed [DATA_W-1:0] m12;
      logic signed [DATA_W-1:0] m20;
      logic signed [DATA_W-1:0] m21;
      logic signed [DATA_W-1:0] m22;
      logic signed [DATA_W-1:0] out_x;
      logic signed [DATA_W-1:0] out_y;
      logic signed [DATA_W-1:0] out_z;
   } rsp_type;

   // side data that rides along the root and divide pipelines
   typedef struct packed {
      logic                   zero;
      logic [2:0]             neg;
      logic [2:0][DATA_W-1:0] mag;
      logic [2:0][DATA_W-1:0] trans;
   } front_type;

   // unit axis and sine/cosine, all Q1.30
   typedef struct packed {
      logic signed [DATA_W-1:0] u0;
      logic signed [DATA_W-1:0] u1;
      logic signed [DATA_W-1:0] u2;
      logic signed [DATA_W-1:0] sn;
      logic signed [DATA_W-1:0] cs;
   } rot_type;

   // atan(2^-i) in Q.30, truncated
   function automatic logic signed [CORDIC_W-1:0] atan_q30(input logic [4:0] idx);
      logic signed [CORDIC_W-1:0] v;
      unique case (idx)
         5'd0:    v = 36'sd843314856;
         5'd1:    v = 36'sd497837829;
         5'd2:    v = 36'sd263043836;
         5'd3:    v = 36'sd133525158;
         5'd4:    v = 36'sd67021686;
         5'd5:    v = 36'sd33543515;
         5'd6:    v = 36'sd16775850;
         5'd7:    v = 36'sd8388437;
         5'd8:    v = 36'sd4194282;
         5'd9:    v = 36'sd2097149;
         5'd10:   v = 36'sd1048575;
         5'd11:   v = 36'sd524287;
         5'd12:   v = 36'sd262143;
         5'd13:   v = 36'sd131071;
         5'd14:   v = 36'sd65535;
         5'd15:   v = 36'sd32767;
         5'd16:   v = 36'sd16383;
         5'd17:   v = 36'sd8191;
         5'd18:   v = 36'sd4095;
         5'd19:   v = 36'sd2047;
         5'd20:   v = 36'sd1023;
         5'd21:   v = 36'sd511;
         5'd22:   v = 36'sd255;
         5'd23:   v = 36'sd127;
         5'd24:   v = 36'sd63;
         5'd25:   v = 36'sd31;
         5'd26:   v = 36'sd15;
         5'd27:   v = 36'sd7;
         5'd28:   v = 36'sd3;
         5'd29:   v = 36'sd1;
         default: v = 36'sd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [71:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > 72'sd2147483647)
         r = 32'sh7fffffff;
      else if (v < -72'sd2147483648)
         r = 32'sh80000000;
      else
         r = v[DATA_W-1:0];
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== design/aapi_root.sv =====
`default_nettype none
// Pipelined integer square root, one result bit per stage
module aapi_root (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [63:0]         in_sq,
   input  aapi_pkg::front_type in_front,
   output logic                out_valid,
   output logic [31:0]         out_root,
   output aapi_pkg::front_type out_front
);
   import aapi_pkg::*;

   logic [ROOT_STEPS-1:0] vld_ff;
   logic [63:0]           rem_ff [ROOT_STEPS];
   logic [63:0]           res_ff [ROOT_STEPS];
   front_type             fr_ff  [ROOT_STEPS];

   for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
      logic        vld_prev;
      logic [63:0] rem_prev, res_prev, trial, rem_in, res_in;
      front_type   fr_prev;

      if (k == 0) begin : g_first
         assign vld_prev = in_valid;
         assign rem_prev = in_sq;
         assign res_prev = '0;
         assign fr_prev  = in_front;
      end else begin : g_next
         assign vld_prev = vld_ff[k-1];
         assign rem_prev = rem_ff[k-1];
         assign res_prev = res_ff[k-1];
         assign fr_prev  = fr_ff[k-1];
      end

      // trial subtract of (res + bit), bit walking down by two places
      always_comb begin
         trial = res_prev | (64'd1 << (62 - 2 * k));
         if (rem_prev >= trial) begin
            rem_in = rem_prev - trial;
            res_in = (res_prev >> 1) | (64'd1 << (62 - 2 * k));
         end else begin
            rem_in = rem_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_prev;
         end
         rem_ff[k] <= rem_in;
         res_ff[k] <= res_in;
         fr_ff[k]  <= fr_prev;
      end
   end

   assign out_valid = vld_ff[ROOT_STEPS-1];
   assign out_root  = res_ff[ROOT_STEPS-1][31:0];
   assign out_front = fr_ff[ROOT_STEPS-1];

endmodule
`default_nettype wire

// ===== design/aapi_rotgen.sv =====
`default_nettype none
// Angle reduction, then axis divide and sine/cosine CORDIC side by side
module aapi_rotgen #(
   parameter int CORDIC_STAGES = aapi_pkg::CORDIC_STAGES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [31:0]         in_theta,
   input  aapi_pkg::front_type in_front,
   output logic                out_valid,
   output aapi_pkg::rot_type   out_rot,
   output aapi_pkg::front_type out_front
);
   import aapi_pkg::*;

   localparam int STAGES = (CORDIC_STAGES > DIV_BITS) ? CORDIC_STAGES : DIV_BITS;

   // reduction stage
   logic                       red_vld_ff;
   logic signed [CORDIC_W-1:0] red_z_ff;
   logic                       red_negc_ff;
   logic [31:0]                red_th_ff;
   logic [61:0]                red_rem_ff [3];
   front_type                  red_fr_ff;
   logic signed [CORDIC_W-1:0] a0, a1, a2, a3, af;
   logic                       negc_in;

   always_comb begin
      a0 = $signed({4'b0, in_theta});
      a1 = (a0 > PI_Q28) ? a0 - TWO_PI_Q28 : a0;
      a2 = (a1 > PI_Q28) ? a1 - TWO_PI_Q28 : a1;
      a3 = (a2 > PI_Q28) ? a2 - TWO_PI_Q28 : a2;
      if (a3 > HALF_PI_Q28) begin
         af      = PI_Q28 - a3;
         negc_in = 1'b1;
      end else if (a3 < -HALF_PI_Q28) begin
         af      = -PI_Q28 - a3;
         negc_in = 1'b1;
      end else begin
         af      = a3;
         negc_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_vld_ff <= 1'b0;
      end else begin
         red_vld_ff <= in_valid;
      end
      red_z_ff    <= af <<< 2;
      red_negc_ff <= negc_in;
      red_th_ff   <= in_theta;
      red_fr_ff   <= in_front;
      for (int i = 0; i < 3; i++) begin
         red_rem_ff[i] <= {in_front.mag[i], 30'b0};
      end
   end

   // shared stage chain: per stage one quotient bit (below DIV_BITS) and one CORDIC rotation (below CORDIC_STAGES)
   logic [STAGES-1:0]          vld_ff;
   logic signed [CORDIC_W-1:0] cx_ff  [STAGES];
   logic signed [CORDIC_W-1:0] cy_ff  [STAGES];
   logic signed [CORDIC_W-1:0] cz_ff  [STAGES];
   logic                       negc_ff[STAGES];
   logic [31:0]                th_ff  [STAGES];
   logic [61:0]                rem_ff [STAGES][3];
   logic [30:0]                quo_ff [STAGES][3];
   front_type                  fr_ff  [STAGES];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic                       vld_prev, negc_prev;
      logic signed [CORDIC_W-1:0] x_prev, y_prev, z_prev, x_in, y_in, z_in;
      logic [31:0]                th_prev;
      logic [61:0]                rem_prev [3];
      logic [61:0]                rem_in   [3];
      logic [30:0]                quo_prev [3];
      logic [30:0]                quo_in   [3];
      front_type                  fr_prev;

      if (k == 0) begin : g_first
         assign vld_prev  = red_vld_ff;
         assign negc_prev = red_negc_ff;
         assign x_prev    = GAIN_Q30;
         assign y_prev    = '0;
         assign z_prev    = red_z_ff;
         assign th_prev   = red_th_ff;
         assign fr_prev   = red_fr_ff;
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign rem_prev[i] = red_rem_ff[i];
            assign quo_prev[i] = '0;
         end
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign negc_prev = negc_ff[k-1];
         assign x_prev    = cx_ff[k-1];
         assign y_prev    = cy_ff[k-1];
         assign z_prev    = cz_ff[k-1];
         assign th_prev   = th_ff[k-1];
         assign fr_prev   = fr_ff[k-1];
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign rem_prev[i] = rem_ff[k-1][i];
            assign quo_prev[i] = quo_ff[k-1][i];
         end
      end

      // restoring divide, quotient bit DIV_BITS-1-k
      if (k < DIV_BITS) begin : g_div
         logic [61:0] dsh;
         assign dsh = {30'b0, th_prev} << (DIV_BITS - 1 - k);
         always_comb begin
            for (int i = 0; i < 3; i++) begin
               if (rem_prev[i] >= dsh) begin
                  rem_in[i] = rem_prev[i] - dsh;
                  quo_in[i] = quo_prev[i] | (31'd1 << (DIV_BITS - 1 - k));
               end else begin
                  rem_in[i] = rem_prev[i];
                  quo_in[i] = quo_prev[i];
               end
            end
         end
      end else begin : g_div_hold
         always_comb begin
            for (int i = 0; i < 3; i++) begin
               rem_in[i] = rem_prev[i];
               quo_in[i] = quo_prev[i];
            end
         end
      end

      // CORDIC rotation k, direction from the sign of z
      if (k < CORDIC_STAGES) begin : g_cordic
         always_comb begin
            if (z_prev >= 0) begin
               x_in = x_prev - (y_prev >>> k);
               y_in = y_prev + (x_prev >>> k);
               z_in = z_prev - atan_q30(5'(k));
            end else begin
               x_in = x_prev + (y_prev >>> k);
               y_in = y_prev - (x_prev >>> k);
               z_in = z_prev + atan_q30(5'(k));
            end
         end
      end else begin : g_cordic_hold
         assign x_in = x_prev;
         assign y_in = y_prev;
         assign z_in = z_prev;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_prev;
         end
         cx_ff[k]   <= x_in;
         cy_ff[k]   <= y_in;
         cz_ff[k]   <= z_in;
         negc_ff[k] <= negc_prev;
         th_ff[k]   <= th_prev;
         fr_ff[k]   <= fr_prev;
         for (int i = 0; i < 3; i++) begin
            rem_ff[k][i] <= rem_in[i];
            quo_ff[k][i] <= quo_in[i];
         end
      end
   end

   // clamp, cosine sign, axis sign
   logic signed [CORDIC_W-1:0] xc, yc, cs_w;
   logic signed [DATA_W-1:0]   u_w [3];

   always_comb begin
      xc = cx_ff[STAGES-1];
      if (xc > ONE_Q30) xc = ONE_Q30;
      if (xc < -ONE_Q30) xc = -ONE_Q30;
      yc = cy_ff[STAGES-1];
      if (yc > ONE_Q30) yc = ONE_Q30;
      if (yc < -ONE_Q30) yc = -ONE_Q30;
      cs_w = negc_ff[STAGES-1] ? -xc : xc;
      for (int i = 0; i < 3; i++) begin
         u_w[i] = fr_ff[STAGES-1].neg[i] ? -$signed({1'b0, quo_ff[STAGES-1][i]})
                                         :  $signed({1'b0, quo_ff[STAGES-1][i]});
      end
   end

   assign out_valid  = vld_ff[STAGES-1];
   assign out_front  = fr_ff[STAGES-1];
   assign out_rot.u0 = u_w[0];
   assign out_rot.u1 = u_w[1];
   assign out_rot.u2 = u_w[2];
   assign out_rot.sn = yc[DATA_W-1:0];
   assign out_rot.cs = cs_w[DATA_W-1:0];

endmodule
`default_nettype wire

// ===== design/axis_angle_pose_inverse.sv =====
// Rodrigues rotation matrix with optional pose inversion, fully pipelined.
// The path from start to rsp_valid runs through these stages:
// 2 square/sum, 32 square-root, 1 reduction, the divide/CORDIC chain and 6 matrix stages.
// Throughput: one item per cycle; busy stays low and results are never held off.
// Synchronous reset clears all valid bits and sets mode to 0; data registers are not reset.
`default_nettype none
module axis_angle_pose_inverse #(
   parameter int CORDIC_STAGES = aapi_pkg::CORDIC_STAGES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  aapi_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   output aapi_pkg::rsp_type                 rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [aapi_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [aapi_pkg::DATA_W-1:0]       pwdata,
   output logic [aapi_pkg::DATA_W-1:0]       prdata,
   output logic                              pready
);
   import aapi_pkg::*;

   // configuration register
   logic mode_ff;

   assign pready = 1'b1;
   assign busy   = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (psel && penable && pwrite && pready && paddr[2] == CSR_IDX_MODE) begin
         mode_ff <= pwdata[0];
      end
   end

   assign prdata = (paddr[2] == CSR_IDX_MODE) ? {{(DATA_W-1){1'b0}}, mode_ff} : '0;

   // stage 0: squares, magnitudes, signs and zero-vector flag
   logic signed [DATA_W-1:0] rot_w [3];
   logic                     s0_vld_ff;
   logic signed [63:0]       sq_ff [3];
   front_type                s0_fr_ff;

   assign rot_w[0] = req_data.rot_x;
   assign rot_w[1] = req_data.rot_y;
   assign rot_w[2] = req_data.rot_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= start && !busy;
      end
      for (int i = 0; i < 3; i++) begin
         sq_ff[i]          <= rot_w[i] * rot_w[i];
         s0_fr_ff.neg[i]   <= rot_w[i][DATA_W-1];
         s0_fr_ff.mag[i]   <= rot_w[i][DATA_W-1] ? (~rot_w[i] + 1'b1) : rot_w[i];
      end
      s0_fr_ff.zero     <= (rot_w[0] == '0) && (rot_w[1] == '0) && (rot_w[2] == '0);
      s0_fr_ff.trans[0] <= req_data.trans_x;
      s0_fr_ff.trans[1] <= req_data.trans_y;
      s0_fr_ff.trans[2] <= req_data.trans_z;
   end

   // stage 1: sum of squares
   logic        s1_vld_ff;
   logic [63:0] s1_sum_ff;
   front_type   s1_fr_ff;
   logic [63:0] sum_in;

   assign sum_in = $unsigned(sq_ff[0]) + $unsigned(sq_ff[1]) + $unsigned(sq_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s0_vld_ff;
      end
      s1_sum_ff      <= sum_in;
      s1_fr_ff       <= s0_fr_ff;
   end

   // theta
   logic        rt_vld;
   logic [31:0] rt_theta;
   front_type   rt_fr;

   aapi_root u_root (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_vld_ff),
      .in_sq     (s1_sum_ff),
      .in_front  (s1_fr_ff),
      .out_valid (rt_vld),
      .out_root  (rt_theta),
      .out_front (rt_fr)
   );

   // unit axis, sine and cosine
   logic      rg_vld;
   rot_type   rg_rot;
   front_type rg_fr;

   aapi_rotgen #(
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_rotgen (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rt_vld),
      .in_theta  (rt_theta),
      .in_front  (rt_fr),
      .out_valid (rg_vld),
      .out_rot   (rg_rot),
      .out_front (rg_fr)
   );

   // P1: axis products, 1 - cos
   logic                     p1_vld_ff;
   logic signed [63:0]       pu_ff [6];
   logic signed [DATA_W-1:0] p1_u_ff [3];
   logic signed [DATA_W-1:0] p1_sn_ff;
   logic signed [32:0]       p1_omc_ff;
   front_type                p1_fr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= rg_vld;
      end
      pu_ff[0]   <= rg_rot.u0 * rg_rot.u0;
      pu_ff[1]   <= rg_rot.u1 * rg_rot.u1;
      pu_ff[2]   <= rg_rot.u2 * rg_rot.u2;
      pu_ff[3]   <= rg_rot.u0 * rg_rot.u1;
      pu_ff[4]   <= rg_rot.u0 * rg_rot.u2;
      pu_ff[5]   <= rg_rot.u1 * rg_rot.u2;
      p1_u_ff[0] <= rg_rot.u0;
      p1_u_ff[1] <= rg_rot.u1;
      p1_u_ff[2] <= rg_rot.u2;
      p1_sn_ff   <= rg_rot.sn;
      p1_omc_ff  <= 33'sd1073741824 - 33'(rg_rot.cs);
      p1_fr_ff   <= rg_fr;
   end

   // P2: K*K entries rounded to Q.30, sine times axis
   // order: kk00, kk01, kk02, kk11, kk12, kk22
   logic                     p2_vld_ff;
   logic signed [35:0]       kk_ff [6];
   logic signed [63:0]       snu_ff [3];
   logic signed [32:0]       p2_omc_ff;
   front_type                p2_fr_ff;
   logic signed [65:0]       kk_sum [6];
   logic signed [65:0]       kk_rnd [6];

   always_comb begin
      kk_sum[0] = -(66'(pu_ff[1]) + 66'(pu_ff[2]));
      kk_sum[1] = 66'(pu_ff[3]);
      kk_sum[2] = 66'(pu_ff[4]);
      kk_sum[3] = -(66'(pu_ff[0]) + 66'(pu_ff[2]));
      kk_sum[4] = 66'(pu_ff[5]);
      kk_sum[5] = -(66'(pu_ff[0]) + 66'(pu_ff[1]));
      for (int i = 0; i < 6; i++) begin
         kk_rnd[i] = (kk_sum[i] + 66'sd536870912) >>> 30;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_vld_ff <= 1'b0;
      end else begin
         p2_vld_ff <= p1_vld_ff;
      end
      for (int i = 0; i < 6; i++) begin
         kk_ff[i] <= kk_rnd[i][35:0];
      end
      for (int i = 0; i < 3; i++) begin
         snu_ff[i] <= p1_sn_ff * p1_u_ff[i];
      end
      p2_omc_ff <= p1_omc_ff;
      p2_fr_ff  <= p1_fr_ff;
   end

   // P3: (1 - cos) * KK products, rounded sine terms for +u and -u
   logic               p3_vld_ff;
   logic signed [68:0] op_ff [6];
   logic signed [33:0] spos_ff [3];
   logic signed [33:0] sneg_ff [3];
   front_type          p3_fr_ff;
   logic signed [64:0] sp_rnd [3];
   logic signed [64:0] sn_rnd [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sp_rnd[i] = (65'(snu_ff[i]) + 65'sd536870912) >>> 30;
         sn_rnd[i] = (-65'(snu_ff[i]) + 65'sd536870912) >>> 30;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_vld_ff <= 1'b0;
      end else begin
         p3_vld_ff <= p2_vld_ff;
      end
      for (int i = 0; i < 6; i++) begin
         op_ff[i] <= 69'(p2_omc_ff) * 69'(kk_ff[i]);
      end
      for (int i = 0; i < 3; i++) begin
         spos_ff[i] <= sp_rnd[i][33:0];
         sneg_ff[i] <= sn_rnd[i][33:0];
      end
      p3_fr_ff <= p2_fr_ff;
   end

   // P4: R = I + sin K + (1 - cos) KK, saturated; identity for a zero vector
   logic                     p4_vld_ff;
   logic signed [DATA_W-1:0] rm_ff [3][3];
   front_type                p4_fr_ff;
   logic signed [68:0]       o_rnd [6];
   logic signed [71:0]       o_w [6];
   logic signed [71:0]       sp_w [3];
   logic signed [71:0]       sm_w [3];
   logic signed [71:0]       one_w;
   logic signed [DATA_W-1:0] rm_in [3][3];

   always_comb begin
      one_w = 72'sd1073741824;
      for (int i = 0; i < 6; i++) begin
         o_rnd[i] = (op_ff[i] + 69'sd536870912) >>> 30;
         o_w[i]   = 72'(o_rnd[i]);
      end
      for (int i = 0; i < 3; i++) begin
         sp_w[i] = 72'(spos_ff[i]);
         sm_w[i] = 72'(sneg_ff[i]);
      end
      rm_in[0][0] = sat32(one_w + o_w[0]);
      rm_in[0][1] = sat32(sm_w[2] + o_w[1]);
      rm_in[0][2] = sat32(sp_w[1] + o_w[2]);
      rm_in[1][0] = sat32(sp_w[2] + o_w[1]);
      rm_in[1][1] = sat32(one_w + o_w[3]);
      rm_in[1][2] = sat32(sm_w[0] + o_w[4]);
      rm_in[2][0] = sat32(sm_w[1] + o_w[2]);
      rm_in[2][1] = sat32(sp_w[0] + o_w[4]);
      rm_in[2][2] = sat32(one_w + o_w[5]);
      if (p3_fr_ff.zero) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               rm_in[i][j] = (i == j) ? 32'sd1073741824 : 32'sd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_vld_ff <= 1'b0;
      end else begin
         p4_vld_ff <= p3_vld_ff;
      end
      rm_ff    <= rm_in;
      p4_fr_ff <= p3_fr_ff;
   end

   // P5: products of R transposed with t
   logic                     p5_vld_ff;
   logic signed [63:0]       tp_ff [3][3];
   logic signed [DATA_W-1:0] p5_rm_ff [3][3];
   logic [2:0][DATA_W-1:0]   p5_t_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p5_vld_ff <= 1'b0;
      end else begin
         p5_vld_ff <= p4_vld_ff;
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            tp_ff[i][j] <= rm_ff[j][i] * $signed(p4_fr_ff.trans[j]);
         end
      end
      p5_rm_ff <= rm_ff;
      p5_t_ff  <= p4_fr_ff.trans;
   end

   // P6: output register, mode select
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;
   logic signed [65:0] tsum [3];
   logic signed [65:0] tsh [3];
   logic signed [DATA_W-1:0] tinv [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tsum[i] = 66'(tp_ff[i][0]) + 66'(tp_ff[i][1]) + 66'(tp_ff[i][2])
                   + 66'sd536870912;
         tsh[i]  = tsum[i] >>> 30;
         tinv[i] = sat32(-72'(tsh[i]));
      end
      if (mode_ff) begin
         rsp_in.m00   = p5_rm_ff[0][0];
         rsp_in.m01   = p5_rm_ff[1][0];
         rsp_in.m02   = p5_rm_ff[2][0];
         rsp_in.m10   = p5_rm_ff[0][1];
         rsp_in.m11   = p5_rm_ff[1][1];
         rsp_in.m12   = p5_rm_ff[2][1];
         rsp_in.m20   = p5_rm_ff[0][2];
         rsp_in.m21   = p5_rm_ff[1][2];
         rsp_in.m22   = p5_rm_ff[2][2];
         rsp_in.out_x = tinv[0];
         rsp_in.out_y = tinv[1];
         rsp_in.out_z = tinv[2];
      end else begin
         rsp_in.m00   = p5_rm_ff[0][0];
         rsp_in.m01   = p5_rm_ff[0][1];
         rsp_in.m02   = p5_rm_ff[0][2];
         rsp_in.m10   = p5_rm_ff[1][0];
         rsp_in.m11   = p5_rm_ff[1][1];
         rsp_in.m12   = p5_rm_ff[1][2];
         rsp_in.m20   = p5_rm_ff[2][0];
         rsp_in.m21   = p5_rm_ff[2][1];
         rsp_in.m22   = p5_rm_ff[2][2];
         rsp_in.out_x = p5_t_ff[0];
         rsp_in.out_y = p5_t_ff[1];
         rsp_in.out_z = p5_t_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= p5_vld_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ===== bench/axis_angle_pose_inverse_tb.sv =====
`default_nettype none
module axis_angle_pose_inverse_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import aapi_pkg::*;

   localparam longint ONE30   = 64'sd1073741824;
   localparam longint PI28    = 64'sd843314857;
   localparam longint TWOPI28 = 64'sd1686629713;
   localparam longint HPI28   = 64'sd421657428;
   localparam longint GAIN30  = 64'sd652032874;
   localparam int     STAGES  = (CORDIC_STAGES_DEF > 32) ? 32 : CORDIC_STAGES_DEF;
   localparam logic [CSR_ADDR_W-1:0] ADDR_MODE  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_SPARE = 3'd4;
   localparam int LATENCY = 41 + ((CORDIC_STAGES_DEF > 31) ? CORDIC_STAGES_DEF : 31);

   // Expected pose store plus the Rodrigues/inverse-pose predictor
   class pose_scoreboard;
      rsp_type pending_poses[$];
      bit      inverse_mode;
      int      mismatches;
      longint  atan_tab[32] = '{
         843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
         16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
         65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
         15, 7, 3, 1, 0, 0};

      function longint clip32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint rnd30(longint v);
         return (v + (64'sd1 <<< 29)) >>> 30;
      endfunction

      function longint unsigned int_root(longint unsigned v);
         longint unsigned res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= res + b) begin
               v = v - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return res;
      endfunction

      // reduce angle, fold past +-pi/2, rotate by CORDIC
      function void sin_cos(longint theta, output longint sn, output longint cs);
         longint a, x, y, z, nx;
         bit flip;
         a = theta;
         flip = 0;
         x = GAIN30;
         y = 0;
         for (int i = 0; i < 3; i++)
            if (a > PI28) a = a - TWOPI28;
         if (a > HPI28) begin
            a = PI28 - a;
            flip = 1;
         end else if (a < -HPI28) begin
            a = -PI28 - a;
            flip = 1;
         end
         z = a * 4;
         for (int i = 0; i < STAGES; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i);
               y  = y + (x >>> i);
               z  = z - atan_tab[i];
            end else begin
               nx = x + (y >>> i);
               y  = y - (x >>> i);
               z  = z + atan_tab[i];
            end
            x = nx;
         end
         if (x > ONE30) x = ONE30;
         if (x < -ONE30) x = -ONE30;
         if (y > ONE30) y = ONE30;
         if (y < -ONE30) y = -ONE30;
         sn = y;
         cs = flip ? -x : x;
      endfunction

      function rsp_type rodrigues_pose(req_type rq);
         longint r[3], t[3], u[3], m[3][3], k[3][3], kk[3][3], tr[3][3], res[3];
         longint sn, cs, omc, acc, hi, lo, p, h;
         longint unsigned s, theta, mag;
         rsp_type o;
         r[0] = longint'(rq.rot_x);   r[1] = longint'(rq.rot_y);
         r[2] = longint'(rq.rot_z);
         t[0] = longint'(rq.trans_x); t[1] = longint'(rq.trans_y);
         t[2] = longint'(rq.trans_z);
         s = 0;
         for (int i = 0; i < 3; i++) s = s + longint'(r[i] * r[i]);
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) m[i][j] = (i == j) ? ONE30 : 0;
         if (s != 0) begin
            theta = int_root(s);
            for (int i = 0; i < 3; i++) begin
               mag = (r[i] < 0) ? -r[i] : r[i];
               acc = longint'((mag << 30) / theta);
               u[i] = (r[i] < 0) ? -acc : acc;
            end
            k[0][0] = 0;     k[0][1] = -u[2]; k[0][2] = u[1];
            k[1][0] = u[2];  k[1][1] = 0;     k[1][2] = -u[0];
            k[2][0] = -u[1]; k[2][1] = u[0];  k[2][2] = 0;
            for (int i = 0; i < 3; i++)
               for (int j = 0; j < 3; j++)
                  kk[i][j] = rnd30(k[i][0] * k[0][j] + k[i][1] * k[1][j]
                                   + k[i][2] * k[2][j]);
            sin_cos(longint'(theta), sn, cs);
            omc = ONE30 - cs;
            for (int i = 0; i < 3; i++)
               for (int j = 0; j < 3; j++)
                  m[i][j] = clip32(m[i][j] + rnd30(sn * k[i][j]) + rnd30(omc * kk[i][j]));
         end
         if (inverse_mode) begin
            for (int i = 0; i < 3; i++)
               for (int j = 0; j < 3; j++) tr[i][j] = m[j][i];
            // -(R^T t), exact sum then round half up to Q.16
            for (int i = 0; i < 3; i++) begin
               hi = 0;
               lo = 0;
               for (int j = 0; j < 3; j++) begin
                  p = tr[i][j] * t[j];
                  h = p >>> 30;
                  hi = hi + h;
                  lo = lo + (p - h * ONE30);
               end
               res[i] = clip32(-(hi + rnd30(lo)));
            end
            m = tr;
         end else begin
            res = t;
         end
         o.m00 = 32'(m[0][0]); o.m01 = 32'(m[0][1]); o.m02 = 32'(m[0][2]);
         o.m10 = 32'(m[1][0]); o.m11 = 32'(m[1][1]); o.m12 = 32'(m[1][2]);
         o.m20 = 32'(m[2][0]); o.m21 = 32'(m[2][1]); o.m22 = 32'(m[2][2]);
         o.out_x = 32'(res[0]); o.out_y = 32'(res[1]); o.out_z = 32'(res[2]);
         return o;
      endfunction

      function void note_pose(req_type rq);
         pending_poses.push_back(rodrigues_pose(rq));
      endfunction

      function void check_pose(rsp_type got);
         string names[12] = '{"m00", "m01", "m02", "m10", "m11", "m12",
                              "m20", "m21", "m22", "out_x", "out_y", "out_z"};
         rsp_type want;
         logic [31:0] w, g;
         if (pending_poses.size() == 0) begin
            $error("unexpected result item %h", got);
            mismatches++;
            return;
         end
         want = pending_poses.pop_front();
         for (int i = 0; i < 12; i++) begin
            w = want[(11 - i) * 32 +: 32];
            g = got[(11 - i) * 32 +: 32];
            if (w !== g) begin
               $error("%s: expected %h, got %h", names[i], w, g);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic pready;

   pose_scoreboard sb = new();

   always #1 clock = ~clock;

   axis_angle_pose_inverse dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready));

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_pose(rsp_data);
   end

   // wait out all expected poses plus pipeline tail
   task automatic drain();
      while (sb.pending_poses.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [31:0] value);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      if (addr == ADDR_MODE) sb.inverse_mode = value[0];
   endtask

   task automatic send_item(req_type rq);
      int gap;
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_data <= rq;
      do @(posedge clock); while (busy);
      sb.note_pose(rq);
   endtask

   function automatic logic [31:0] rot_value(int kind);
      case (kind)
         0: return $urandom;
         1: return $urandom_range(0, 32'h7fffffff) - 32'h40000000;
         2: return $urandom_range(0, 32'h1fffffff) - 32'h10000000;
         default: return $urandom_range(0, 255) - 128;
      endcase
   endfunction

   function automatic logic [31:0] trans_value();
      case ($urandom_range(0, 7))
         0: return 32'h80000000;
         1: return 32'h7fffffff;
         2: return $urandom_range(0, 32'hffff) - 32'h8000;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_item();
      req_type rq;
      int kind, pick;
      kind = $urandom_range(0, 3);
      pick = $urandom_range(0, 15);
      rq.rot_x = rot_value(kind);
      rq.rot_y = rot_value(kind);
      rq.rot_z = rot_value(kind);
      // zero vector and single-axis rotations now and then
      if (pick == 0) begin
         rq.rot_x = 0; rq.rot_y = 0; rq.rot_z = 0;
      end else if (pick == 1) begin
         rq.rot_y = 0; rq.rot_z = 0;
      end else if (pick == 2) begin
         rq.rot_x = 0; rq.rot_z = 0;
      end
      rq.trans_x = trans_value();
      rq.trans_y = trans_value();
      rq.trans_z = trans_value();
      return rq;
   endfunction

   function automatic req_type mk(logic [31:0] rx, logic [31:0] ry, logic [31:0] rz,
                                  logic [31:0] tx, logic [31:0] ty, logic [31:0] tz);
      req_type rq;
      rq.rot_x = rx; rq.rot_y = ry; rq.rot_z = rz;
      rq.trans_x = tx; rq.trans_y = ty; rq.trans_z = tz;
      return rq;
   endfunction

   task automatic directed_set();
      send_item(mk(0, 0, 0, 32'h00010000, 32'hffff0000, 32'h12345678));
      send_item(mk(0, 0, 0, 32'h80000000, 32'h7fffffff, 0));
      send_item(mk(32'h80000000, 32'h80000000, 32'h80000000,
                   32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
      send_item(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                   32'h80000000, 32'h80000000, 32'h80000000));
      send_item(mk(32'h7fffffff, 0, 0, 32'h00010000, 0, 0));
      send_item(mk(0, 32'h80000000, 0, 0, 32'h00010000, 0));
      send_item(mk(0, 0, 32'd843314857, 32'h7fffffff, 32'h80000000, 1));
      send_item(mk(0, 0, 32'd421657428, 32'h00010000, 32'h00020000, 0));
      send_item(mk(32'd421657429, 0, 0, 0, 32'h00010000, 32'h00010000));
      send_item(mk(0, 32'd1686629713, 0, 32'hffffffff, 1, 0));
      send_item(mk(1, 0, 0, 32'h00010000, 0, 0));
      send_item(mk(32'hffffffff, 1, 32'hffffffff, 5, 6, 7));
      send_item(mk(32'd200000000, 32'hf0000000, 32'd300000000,
                   32'h7fffffff, 32'h7fffffff, 32'h80000000));
   endtask

   initial begin
      #1_000_000;
      $display("axis_angle_pose_inverse regression: fail");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // forward pass, the spare register (must be ignored), then an inverse pass
      directed_set();
      start <= 0;
      drain();
      csr_write(ADDR_SPARE, 32'hffffffff);
      csr_write(ADDR_MODE, 32'hffffffff);
      directed_set();
      start <= 0;
      drain();
      csr_write(ADDR_SPARE, 32'h0);

      // random phases, alternating mode with odd upper bits in the data
      for (int ph = 0; ph < 4; ph++) begin
         for (int n = 0; n < 175; n++) begin
            if (ph == 1 && n == 80) begin
               start <= 0;
               while (sb.pending_poses.size() != 0) @(posedge clock);
            end
            send_item(random_item());
         end
         start <= 0;
         drain();
         csr_write(ADDR_MODE, (ph[0] ? 32'h80000001 : 32'hfffffffe));
      end

      if (sb.mismatches == 0 && sb.pending_poses.size() == 0)
         $display("axis_angle_pose_inverse regression: pass");
      else
         $display("axis_angle_pose_inverse regression: fail");
      $finish;
   end
endmodule
`default_nettype wire
